FILE: hdl/sprite_screen_projection_assert.svh
// Assertion macros shared by the sprite projection RTL.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef SPRITE_SCREEN_PROJECTION_ASSERT_SVH
`define SPRITE_SCREEN_PROJECTION_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/ssp_pkg.sv
// Package for the sprite screen projection block: constants, stage map, register codes.
// No dependencies.
`timescale 1ns / 1ps

package ssp_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int DIR_FRAC      = 14;
    localparam int DIV_W         = 32;
    localparam int DIV_STEPS     = DIV_W;
    localparam int CFG_ADDR_W    = 5;

    // pipeline stage map
    localparam int ST_DIFF = 0;
    localparam int ST_MUL  = 1;
    localparam int ST_NSUB = 2;
    localparam int ST_ABS  = 3;
    localparam int ST_DIVA = 4;
    localparam int ST_SAT  = ST_DIVA + DIV_STEPS;
    localparam int ST_SUM  = ST_SAT + 1;
    localparam int ST_PROD = ST_SUM + 1;
    localparam int ST_PABS = ST_PROD + 1;
    localparam int ST_DIVB = ST_PABS + 1;
    localparam int ST_RES  = ST_DIVB + DIV_STEPS;
    localparam int ST_OUT  = ST_RES + 1;
    localparam int NST     = ST_OUT + 1;

    typedef enum logic [2:0] {
        CFG_CAM_X    = 3'd0,
        CFG_CAM_Y    = 3'd1,
        CFG_DIR_X    = 3'd2,
        CFG_DIR_Y    = 3'd3,
        CFG_PLANE_X  = 3'd4,
        CFG_PLANE_Y  = 3'd5,
        CFG_WIDTH    = 3'd6,
        CFG_HEIGHT   = 3'd7
    } cfg_idx_t;

    localparam logic [31:0] RST_CAM_X   = 32'd0;
    localparam logic [31:0] RST_CAM_Y   = 32'd0;
    localparam logic [15:0] RST_DIR_X   = 16'hC000;
    localparam logic [15:0] RST_DIR_Y   = 16'd0;
    localparam logic [15:0] RST_PLANE_X = 16'd0;
    localparam logic [15:0] RST_PLANE_Y = 16'd10813;
    localparam logic [12:0] RST_WIDTH   = 13'd640;
    localparam logic [12:0] RST_HEIGHT  = 13'd480;

    localparam logic [11:0] ROW_MAX  = 12'd4095;
    localparam logic [15:0] COL_SAT  = 16'd32767;
    localparam logic [15:0] SIZE_SAT = 16'd65535;

    // Apply sign to a quotient magnitude and saturate to 32-bit signed.
    function automatic logic [31:0] sat32(input logic [31:0] q, input logic ovf,
                                          input logic neg);
        logic [31:0] r;
        if (!neg) begin
            if (ovf || q[31])
                r = 32'h7FFF_FFFF;
            else
                r = q;
        end
        else begin
            if (ovf || (q > 32'h8000_0000))
                r = 32'h8000_0000;
            else
                r = 32'(-q);
        end
        return r;
    endfunction

endpackage

FILE: hdl/ssp_if.sv
// Handshake channels of the sprite projection block: sprite in, projection out.
// No dependencies.
`timescale 1ns / 1ps

interface ssp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sprite_x;
    logic signed [31:0] sprite_y;

    modport source (output valid, sprite_x, sprite_y, input ready);
    modport sink   (input valid, sprite_x, sprite_y, output ready);
endinterface

interface ssp_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] screen_column;
    logic        [15:0] sprite_size;
    logic        [11:0] start_row;
    logic        [11:0] end_row;
    logic signed [16:0] start_col;
    logic signed [16:0] end_col;
    logic signed [31:0] depth;
    logic               visible;

    modport source (output valid, screen_column, sprite_size, start_row, end_row,
                    start_col, end_col, depth, visible, input ready);
    modport sink   (input valid, screen_column, sprite_size, start_row, end_row,
                    start_col, end_col, depth, visible, output ready);
endinterface

FILE: hdl/ssp_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on ssp_pkg; stage enables come from the caller's flow control.
`timescale 1ns / 1ps

module ssp_div
    import ssp_pkg::*;
(
    input  logic                   clk,
    input  logic [DIV_STEPS-1:0]   en,
    input  logic [2*DIV_W-1:0]     num,
    input  logic [DIV_W-1:0]       den,
    output logic [DIV_W-1:0]       quo,
    output logic                   ovf
);

    logic [DIV_W-1:0] rem_reg [DIV_STEPS];
    logic [DIV_W-1:0] lo_reg  [DIV_STEPS];
    logic [DIV_W-1:0] q_reg   [DIV_STEPS];
    logic [DIV_W-1:0] den_reg [DIV_STEPS];
    logic             ovf_reg [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        logic [DIV_W-1:0] rem_in, lo_in, q_in, den_in;
        logic             ovf_in;
        logic [DIV_W:0]   part, diff;
        logic             ge;

        if (j == 0) begin : g_first
            assign rem_in = num[2*DIV_W-1:DIV_W];
            assign lo_in  = num[DIV_W-1:0];
            assign q_in   = '0;
            assign den_in = den;
            // quotient would not fit in DIV_W bits
            assign ovf_in = (num >= {den, {DIV_W{1'b0}}});
        end
        else begin : g_next
            assign rem_in = rem_reg[j-1];
            assign lo_in  = lo_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign den_in = den_reg[j-1];
            assign ovf_in = ovf_reg[j-1];
        end

        assign part = {rem_in, lo_in[DIV_W-1]};
        assign diff = part - {1'b0, den_in};
        assign ge   = !diff[DIV_W];

        always_ff @(posedge clk) begin
            if (en[j]) begin
                rem_reg[j] <= ge ? diff[DIV_W-1:0] : part[DIV_W-1:0];
                lo_reg[j]  <= {lo_in[DIV_W-2:0], 1'b0};
                q_reg[j]   <= {q_in[DIV_W-2:0], ge};
                den_reg[j] <= den_in;
                ovf_reg[j] <= ovf_in;
            end
        end
    end

    assign quo = q_reg[DIV_STEPS-1];
    assign ovf = ovf_reg[DIV_STEPS-1];

endmodule

FILE: hdl/sprite_screen_projection.sv
// Sprite screen projection top level: APB register file, flow control, datapath.
// Depends on ssp_pkg, ssp_if and ssp_div, and on sprite_screen_projection_assert.svh.
`timescale 1ns / 1ps
//
// Usage:
//   sprite_in carries one sprite world position (sprite_x, sprite_y, Q16.16) per
//   transaction; proj_out carries one projection result per transaction, in order.
//   A transaction completes on a rising edge with valid and ready both high.
//   Camera position, direction, plane and screen size sit in APB registers at
//   byte offsets 0x00..0x1C; write them only while no sprite is in flight.
// Pipeline and throughput:
//   74 register stages. One sprite per cycle is sustained while proj_out.ready
//   stays high; the length comes from two chained 32-stage restoring
//   dividers (transform first, then column and size).
// Stall behavior:
//   Each stage has its own valid bit and loads when empty or when the stage
//   after it moves, so bubbles fill while proj_out is stalled; sprite_in.ready
//   drops only when every stage holds a sprite.
// Reset:
//   rst_n clears all valid bits and loads the register reset values
//   (direction -1.0, plane 0.66, 640x480 screen).
`include "sprite_screen_projection_assert.svh"

module sprite_screen_projection
    import ssp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    ssp_in_if.sink                sprite_in,
    ssp_out_if.source             proj_out
);

    // ---------------- configuration registers ----------------
    logic signed [31:0] cam_x_reg, cam_y_reg;
    logic signed [15:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic        [12:0] width_reg, height_reg;
    logic               cfg_wr;
    cfg_idx_t           cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = cfg_idx_t'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cam_x_reg   <= RST_CAM_X;
            cam_y_reg   <= RST_CAM_Y;
            dir_x_reg   <= RST_DIR_X;
            dir_y_reg   <= RST_DIR_Y;
            plane_x_reg <= RST_PLANE_X;
            plane_y_reg <= RST_PLANE_Y;
            width_reg   <= RST_WIDTH;
            height_reg  <= RST_HEIGHT;
        end
        else if (cfg_wr) begin
            case (cfg_sel)
                CFG_CAM_X:   cam_x_reg   <= pwdata;
                CFG_CAM_Y:   cam_y_reg   <= pwdata;
                CFG_DIR_X:   dir_x_reg   <= pwdata[15:0];
                CFG_DIR_Y:   dir_y_reg   <= pwdata[15:0];
                CFG_PLANE_X: plane_x_reg <= pwdata[15:0];
                CFG_PLANE_Y: plane_y_reg <= pwdata[15:0];
                CFG_WIDTH:   width_reg   <= pwdata[12:0];
                CFG_HEIGHT:  height_reg  <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            CFG_CAM_X:   prdata = cam_x_reg;
            CFG_CAM_Y:   prdata = cam_y_reg;
            CFG_DIR_X:   prdata = {16'd0, dir_x_reg};
            CFG_DIR_Y:   prdata = {16'd0, dir_y_reg};
            CFG_PLANE_X: prdata = {16'd0, plane_x_reg};
            CFG_PLANE_Y: prdata = {16'd0, plane_y_reg};
            CFG_WIDTH:   prdata = {19'd0, width_reg};
            CFG_HEIGHT:  prdata = {19'd0, height_reg};
            default:     prdata = '0;
        endcase
    end

    // Camera determinant depends on registers only; the user must hold them still
    // while sprites are in flight (the block does not enforce it), so every stage may read it directly.
    logic signed [31:0] det_a, det_b;
    logic        [32:0] det;
    logic               det_neg, det_zero;
    logic        [31:0] det_abs;

    assign det_a    = plane_x_reg * dir_y_reg;
    assign det_b    = dir_x_reg * plane_y_reg;
    assign det      = {det_a[31], det_a} - {det_b[31], det_b};
    assign det_neg  = det[32];
    assign det_zero = (det == '0);
    assign det_abs  = det_neg ? 32'(-det) : det[31:0];

    // ---------------- flow control ----------------
    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    always_comb begin
        en[NST-1] = !v_reg[NST-1] || proj_out.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign sprite_in.ready = en[0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= '0;
        end
        else begin
            if (en[0])
                v_reg[0] <= sprite_in.valid;
            for (int k = 1; k < NST; k++) begin
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // ---------------- front end: offsets, products, numerators ----------------
    logic signed [32:0] dx_reg, dy_reg;
    logic signed [48:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic        [49:0] nx_reg, ny_reg;
    logic        [49:0] nabs_x_reg, nabs_y_reg;
    logic               negx_reg, negy_reg;

    always_ff @(posedge clk) begin
        if (en[ST_DIFF]) begin
            dx_reg <= {sprite_in.sprite_x[31], sprite_in.sprite_x} - {cam_x_reg[31], cam_x_reg};
            dy_reg <= {sprite_in.sprite_y[31], sprite_in.sprite_y} - {cam_y_reg[31], cam_y_reg};
        end
        if (en[ST_MUL]) begin
            p1_reg <= dir_y_reg * dx_reg;
            p2_reg <= dir_x_reg * dy_reg;
            p3_reg <= plane_x_reg * dy_reg;
            p4_reg <= plane_y_reg * dx_reg;
        end
        if (en[ST_NSUB]) begin
            nx_reg <= {p1_reg[48], p1_reg} - {p2_reg[48], p2_reg};
            ny_reg <= {p3_reg[48], p3_reg} - {p4_reg[48], p4_reg};
        end
        if (en[ST_ABS]) begin
            nabs_x_reg <= nx_reg[49] ? 50'(-nx_reg) : nx_reg;
            nabs_y_reg <= ny_reg[49] ? 50'(-ny_reg) : ny_reg;
            negx_reg   <= nx_reg[49] ^ det_neg;
            negy_reg   <= ny_reg[49] ^ det_neg;
        end
    end

    // ---------------- camera transform dividers ----------------
    logic [DIV_W-1:0] qx, qy;
    logic             ovfx, ovfy;

    ssp_div u_div_tx (
        .clk (clk),
        .en  (en[ST_DIVA +: DIV_STEPS]),
        .num ({nabs_x_reg, {DIR_FRAC{1'b0}}}),
        .den (det_abs),
        .quo (qx),
        .ovf (ovfx)
    );

    ssp_div u_div_ty (
        .clk (clk),
        .en  (en[ST_DIVA +: DIV_STEPS]),
        .num ({nabs_y_reg, {DIR_FRAC{1'b0}}}),
        .den (det_abs),
        .quo (qy),
        .ovf (ovfy)
    );

    // carry the quotient signs alongside the divider
    logic [1:0] sign_a_reg [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_side_a
        always_ff @(posedge clk) begin
            if (en[ST_DIVA + j]) begin
                if (j == 0)
                    sign_a_reg[j] <= {negx_reg, negy_reg};
                else
                    sign_a_reg[j] <= sign_a_reg[(j == 0) ? 0 : j - 1];
            end
        end
    end

    // ---------------- saturate, sum, column numerator ----------------
    logic signed [31:0] tx_reg, ty_reg;
    logic signed [32:0] sum_reg;
    logic signed [31:0] ty2_reg, ty3_reg, ty4_reg;
    logic signed [45:0] prod_reg;
    logic        [45:0] pabs_reg;
    logic               pneg_reg;
    logic [DIV_STEPS-1:0] side_unused;
    logic [11:0]        half_w;

    assign half_w      = width_reg[12:1];
    assign side_unused = '0;

    always_ff @(posedge clk) begin
        if (en[ST_SAT]) begin
            tx_reg <= sat32(qx, ovfx, sign_a_reg[DIV_STEPS-1][1]);
            ty_reg <= sat32(qy, ovfy, sign_a_reg[DIV_STEPS-1][0]);
        end
        if (en[ST_SUM]) begin
            sum_reg <= {tx_reg[31], tx_reg} + {ty_reg[31], ty_reg};
            ty2_reg <= ty_reg;
        end
        if (en[ST_PROD]) begin
            prod_reg <= $signed({1'b0, half_w}) * sum_reg;
            ty3_reg  <= ty2_reg;
        end
        if (en[ST_PABS]) begin
            pabs_reg <= prod_reg[45] ? 46'(-prod_reg) : prod_reg;
            pneg_reg <= prod_reg[45];
            ty4_reg  <= ty3_reg;
        end
    end

    // ---------------- column and size dividers ----------------
    logic [DIV_W-1:0] qc, qs;
    logic             ovfc, ovfs;

    ssp_div u_div_col (
        .clk (clk),
        .en  (en[ST_DIVB +: DIV_STEPS]),
        .num ((2*DIV_W)'(pabs_reg)),
        .den (ty4_reg),
        .quo (qc),
        .ovf (ovfc)
    );

    ssp_div u_div_size (
        .clk (clk),
        .en  (en[ST_DIVB +: DIV_STEPS]),
        .num ((2*DIV_W)'(height_reg) << FRACTION_BITS),
        .den (ty4_reg),
        .quo (qs),
        .ovf (ovfs)
    );

    // carry depth and column sign alongside the second divider
    logic [32:0] side_b_reg [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_side_b
        always_ff @(posedge clk) begin
            if (en[ST_DIVB + j]) begin
                if (j == 0)
                    side_b_reg[j] <= {pneg_reg, ty4_reg};
                else
                    side_b_reg[j] <= side_b_reg[(j == 0) ? 0 : j - 1] | 33'(side_unused[j]);
            end
        end
    end

    // ---------------- column, size, visibility ----------------
    logic signed [15:0] col_reg;
    logic        [15:0] size_reg;
    logic signed [31:0] depth_reg;
    logic               vis_reg;
    logic signed [31:0] ty_b;
    logic               pneg_b, vis_b;
    logic        [15:0] col_mag;

    assign ty_b    = side_b_reg[DIV_STEPS-1][31:0];
    assign pneg_b  = side_b_reg[DIV_STEPS-1][32];
    assign vis_b   = !det_zero && (ty_b > 0);
    assign col_mag = (ovfc || (qc > 32'(COL_SAT))) ? COL_SAT : qc[15:0];

    always_ff @(posedge clk) begin
        if (en[ST_RES]) begin
            vis_reg   <= vis_b;
            depth_reg <= det_zero ? '0 : ty_b;
            if (vis_b) begin
                col_reg  <= pneg_b ? 16'(-col_mag) : col_mag;
                size_reg <= (ovfs || (qs > 32'(SIZE_SAT))) ? SIZE_SAT : qs[15:0];
            end
            else begin
                col_reg  <= '0;
                size_reg <= '0;
            end
        end
    end

    // ---------------- draw bounds and output register ----------------
    logic        [14:0] half_s;
    logic        [11:0] half_h;
    logic signed [16:0] srow_s;
    logic        [16:0] erow_s;
    logic        [12:0] h_m1;
    logic signed [17:0] scol_s, ecol_s;
    logic        [11:0] srow_c, erow_c;
    logic        [16:0] scol_c, ecol_c;

    assign half_s = size_reg[15:1];
    assign half_h = height_reg[12:1];
    assign srow_s = {5'd0, half_h} - {2'd0, half_s};
    assign erow_s = {2'd0, half_s} + {5'd0, half_h};
    assign h_m1   = height_reg - 13'd1;
    assign scol_s = {col_reg[15], col_reg[15], col_reg} - {3'd0, half_s};
    assign ecol_s = {col_reg[15], col_reg[15], col_reg} + {3'd0, half_s};

    always_comb begin
        // start row: drop below zero, limit to the row range
        if (srow_s[16])
            srow_c = '0;
        else if (srow_s > $signed({5'd0, ROW_MAX}))
            srow_c = ROW_MAX;
        else
            srow_c = srow_s[11:0];

        // end row: hold inside the screen, then inside the row range
        if (erow_s >= {4'd0, height_reg}) begin
            if (height_reg == '0)
                erow_c = '0;
            else if (h_m1 > {1'b0, ROW_MAX})
                erow_c = ROW_MAX;
            else
                erow_c = h_m1[11:0];
        end
        else if (erow_s > {5'd0, ROW_MAX})
            erow_c = ROW_MAX;
        else
            erow_c = erow_s[11:0];

        scol_c = scol_s[17] ? '0 : scol_s[16:0];

        if (ecol_s >= $signed({5'd0, width_reg}))
            ecol_c = {4'd0, width_reg} - 17'd1;
        else
            ecol_c = ecol_s[16:0];
    end

    logic signed [15:0] o_col_reg;
    logic        [15:0] o_size_reg;
    logic        [11:0] o_srow_reg, o_erow_reg;
    logic        [16:0] o_scol_reg, o_ecol_reg;
    logic signed [31:0] o_depth_reg;
    logic               o_vis_reg;

    always_ff @(posedge clk) begin
        if (en[ST_OUT]) begin
            o_col_reg   <= col_reg;
            o_size_reg  <= size_reg;
            o_depth_reg <= depth_reg;
            o_vis_reg   <= vis_reg;
            o_srow_reg  <= vis_reg ? srow_c : '0;
            o_erow_reg  <= vis_reg ? erow_c : '0;
            o_scol_reg  <= vis_reg ? scol_c : '0;
            o_ecol_reg  <= vis_reg ? ecol_c : '0;
        end
    end

    assign proj_out.valid         = v_reg[ST_OUT];
    assign proj_out.screen_column = o_col_reg;
    assign proj_out.sprite_size   = o_size_reg;
    assign proj_out.start_row     = o_srow_reg;
    assign proj_out.end_row       = o_erow_reg;
    assign proj_out.start_col     = o_scol_reg;
    assign proj_out.end_col       = o_ecol_reg;
    assign proj_out.depth         = o_depth_reg;
    assign proj_out.visible       = o_vis_reg;

    // ---------------- assertions ----------------
    `SSP_ASSERT_NOW(a_full_when_blocked, !sprite_in.ready, &v_reg,
        "sprite_in stalled while a stage is empty")
    `SSP_ASSERT_NEXT(a_entry_valid, sprite_in.valid && sprite_in.ready, v_reg[ST_DIFF],
        "accepted sprite did not enter the first stage")
    `SSP_ASSERT_NOW(a_visible_depth, proj_out.valid && proj_out.visible,
        (proj_out.depth > 0) && !proj_out.start_col[16],
        "visible result with non-positive depth or negative start column")
    `SSP_ASSERT_NOW(a_hidden_zero, proj_out.valid && !proj_out.visible,
        (proj_out.sprite_size == '0) && (proj_out.screen_column == '0)
        && (proj_out.end_col == '0),
        "hidden result carries nonzero fields")

endmodule
